// File: hdl/fps_pkg.sv
// Package for the farthest point sampler: shared types and constants.
// No dependencies; every other file of the block imports it.
package fps_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned DIST_W  = 36;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 7'd16;

    // Command word passed from the loader to the sampling engine.
    typedef struct packed {
        logic        wr;        // store this point
        logic        run;       // cloud is complete, start sampling
        logic        dropped;   // overflow flag for this cloud
        logic [CNT_W-1:0] cnt;  // effective sample count
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SMALL,
        S_EMPTY,
        S_FIRST,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

// File: hdl/fps_if.sv
// Valid/ready channel interfaces for the farthest point sampler.
// Depends on fps_pkg for field widths.
interface fps_in_if;
    import fps_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic last_point;
    modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface fps_out_if;
    import fps_pkg::*;
    logic valid;
    logic ready;
    logic [9:0] point_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic last_sample;
    logic empty_res;
    logic overflow;
    modport source (output valid, point_index, out_x, out_y, out_z, last_sample,
                    empty_res, overflow, input ready);
    modport sink   (input valid, point_index, out_x, out_y, out_z, last_sample,
                    empty_res, overflow, output ready);
endinterface

interface fps_cfg_if;
    import fps_pkg::*;
    logic valid;
    logic ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/fps_front.sv
// Front end: accepts point words, tracks cloud fill and overflow, and
// pushes store or run commands into a short queue. Depends on fps_pkg.
module fps_front #(
    parameter int unsigned MAX_POINTS  = 1024,
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned AW = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [3*fps_pkg::COORD_W-1:0] i_pos,
    input  logic i_last,
    input  logic [fps_pkg::CNT_W-1:0] i_sample_count,
    // queue output
    output logic o_q_valid,
    input  logic i_q_pop,
    output fps_pkg::t_cmd o_q_cmd,
    output logic [AW-1:0] o_q_addr,
    output logic [AW:0] o_q_n,
    output logic [3*fps_pkg::COORD_W-1:0] o_q_pos
);
    import fps_pkg::*;

    localparam int unsigned QD = 2;
    localparam logic [CNT_W-1:0] MAX_S = CNT_W'(MAX_SAMPLES);
    localparam logic [AW:0] MAX_P = (AW+1)'(MAX_POINTS);

    typedef struct packed {
        t_cmd cmd;
        logic [AW-1:0] addr;
        logic [AW:0] n;
        logic [3*COORD_W-1:0] pos;
    } t_entry;

    t_entry r_q [QD];
    logic   r_rd, r_wr;
    logic [1:0] r_fill;
    logic [AW:0] r_loaded;
    logic r_drop;
    logic push, pop, room;
    t_entry e;
    logic [AW:0] n_loaded;

    assign o_ready = (r_fill != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_q_pop && (r_fill != 2'd0);
    assign room    = (r_loaded < MAX_P);

    // Build the command word for an accepted point.
    always_comb begin
        n_loaded      = r_loaded + (AW+1)'(room);
        e.cmd.wr      = room;
        e.cmd.run     = i_last;
        e.cmd.dropped = r_drop || !room;
        e.cmd.cnt     = (i_sample_count > MAX_S) ? MAX_S : i_sample_count;
        e.addr        = r_loaded[AW-1:0];
        e.n           = n_loaded;
        e.pos         = i_pos;
    end

    // Fill count, overflow flag and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_drop   <= 1'b0;
            r_rd     <= 1'b0;
            r_wr     <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
                if (i_last) begin
                    r_loaded <= '0;
                    r_drop   <= 1'b0;
                end else begin
                    r_loaded <= n_loaded;
                    r_drop   <= e.cmd.dropped;
                end
            end
            if (pop) r_rd <= !r_rd;
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= e;
    end

    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd   = r_q[r_rd].cmd;
    assign o_q_addr  = r_q[r_rd].addr;
    assign o_q_n     = r_q[r_rd].n;
    assign o_q_pos   = r_q[r_rd].pos;
endmodule

// File: hdl/fps_back.sv
// Back end: point memory, nearest-distance memory and the sampling
// sequencer with its output register. Depends on fps_pkg.
module fps_back #(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned AW = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_pop,
    input  fps_pkg::t_cmd i_q_cmd,
    input  logic [AW-1:0] i_q_addr,
    input  logic [AW:0] i_q_n,
    input  logic [3*fps_pkg::COORD_W-1:0] i_q_pos,
    output logic o_valid,
    input  logic i_ready,
    output logic [9:0] o_point_index,
    output logic [3*fps_pkg::COORD_W-1:0] o_pos,
    output logic o_last_sample,
    output logic o_empty_res,
    output logic o_overflow
);
    import fps_pkg::*;

    localparam int unsigned CW = COORD_W;
    localparam int unsigned DW = 2*CW+2; // one squared coordinate difference

    // Memories.
    logic [3*CW-1:0] r_pmem [MAX_POINTS];
    logic [DIST_W-1:0] r_dmem [MAX_POINTS];

    t_state r_state, n_state;
    logic [AW:0] r_n;
    logic [CNT_W-1:0] r_cnt, r_done;
    logic r_drop;
    logic r_first;                    // first pass: every nearest distance starts at all ones
    logic [AW:0] r_j;                 // scan address
    logic [AW-1:0] r_sel;             // latest sample
    logic [3*CW-1:0] r_ref;           // latest sample coordinates, also the output word
    logic r_wait;                     // set while the emit path waits for the point memory read

    // Pipeline of the scan.
    logic        r_p1_v, r_p2_v, r_p3_v;
    logic [AW-1:0] r_p1_j, r_p2_j, r_p3_j;
    logic [DIST_W-1:0] r_p2_old;
    logic [DW-1:0] r_sx, r_sy, r_sz;
    logic [DIST_W-1:0] r_p3_d;
    logic [DIST_W-1:0] r_best_d;
    logic [AW-1:0] r_best;
    logic [DIST_W-1:0] r_dm1;
    logic [DIST_W-1:0] oldd_p1;

    // Read port of the point memory.
    logic [AW-1:0] rd_addr;
    logic [3*CW-1:0] r_rd;
    logic r_out_v;
    logic [9:0] r_oidx;
    logic r_olast, r_oempty, r_odrop;

    logic out_free;
    assign out_free = !r_out_v || i_ready;

    logic [AW:0] n_cnt_ext;
    assign n_cnt_ext = (AW+1)'(i_q_cmd.cnt);

    // Differences and squares for the incoming point pair.
    logic signed [CW:0] dx, dy, dz;
    logic signed [2*CW+1:0] px, py, pz;
    always_comb begin
        dx = $signed({r_rd[3*CW-1], r_rd[3*CW-1 -: CW]}) -
             $signed({r_ref[3*CW-1], r_ref[3*CW-1 -: CW]});
        dy = $signed({r_rd[2*CW-1], r_rd[2*CW-1 -: CW]}) -
             $signed({r_ref[2*CW-1], r_ref[2*CW-1 -: CW]});
        dz = $signed({r_rd[CW-1], r_rd[CW-1:0]}) -
             $signed({r_ref[CW-1], r_ref[CW-1:0]});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // Sequencer: next state, queue pop and emit decisions.
    logic issue, emit_now, pop_q;
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        emit_now = 1'b0;
        pop_q    = 1'b0;
        rd_addr  = r_j[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    pop_q = 1'b1;
                    if (i_q_cmd.run) begin
                        if (i_q_n <= n_cnt_ext && i_q_n != '0) n_state = S_SMALL;
                        else if (i_q_cmd.cnt == '0 || i_q_n == '0) n_state = S_EMPTY;
                        else n_state = S_FIRST;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    emit_now = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SMALL: begin
                if (r_wait && out_free) begin
                    emit_now = 1'b1;
                    if (r_j + 1'b1 == r_n) n_state = S_IDLE;
                end
            end
            S_FIRST, S_EMIT: begin
                rd_addr = r_sel;
                if (r_wait && out_free) begin
                    emit_now = 1'b1;
                    n_state  = (r_done + 1'b1 == r_cnt) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN: begin
                issue = 1'b1;
                if (r_j >= r_n) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v && !r_p3_v) n_state = S_EMIT;
            end
            default: ;
        endcase
        o_q_pop = pop_q;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Squared distance sum and running minimum.
    logic [DIST_W-1:0] sum3, newd;
    always_comb begin
        sum3 = DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        newd = (sum3 < r_p2_old) ? sum3 : r_p2_old;
    end

    // Main registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_p1_v <= issue && (r_j < r_n);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            if (emit_now) r_out_v <= 1'b1;
            else if (i_ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_wait <= 1'b0;
                    if (i_q_valid && i_q_cmd.run) begin
                        r_n    <= i_q_n;
                        r_cnt  <= i_q_cmd.cnt;
                        r_drop <= i_q_cmd.dropped;
                        r_j    <= '0;
                        r_sel  <= '0;
                        r_done <= '0;
                    end
                end
                S_EMPTY: begin
                    if (emit_now) begin
                        r_oidx   <= '0;
                        r_olast  <= 1'b1;
                        r_oempty <= 1'b1;
                        r_odrop  <= r_drop;
                    end
                end
                S_SMALL: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (emit_now) begin
                        r_wait   <= 1'b0;
                        r_oidx   <= 10'(r_j);
                        r_olast  <= (r_j + 1'b1 == r_n);
                        r_oempty <= 1'b0;
                        r_odrop  <= r_drop;
                        r_ref    <= r_rd;
                        r_j      <= r_j + 1'b1;
                    end
                end
                S_FIRST, S_EMIT: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (emit_now) begin
                        r_wait   <= 1'b0;
                        r_oidx   <= 10'(r_sel);
                        r_ref    <= r_rd;
                        r_done   <= r_done + 1'b1;
                        r_olast  <= (r_done + 1'b1 == r_cnt);
                        r_oempty <= 1'b0;
                        r_odrop  <= r_drop;
                        r_first  <= (r_state == S_FIRST);
                        r_j      <= '0;
                        r_best_d <= '0;
                        r_best   <= '0;
                    end
                end
                S_SCAN: begin
                    r_j <= r_j + 1'b1;
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v && !r_p3_v) r_sel <= r_best;
                end
                default: ;
            endcase
            // Final compare stage of the scan.
            if (r_p3_v) begin
                if (r_p3_d > r_best_d) begin
                    r_best_d <= r_p3_d;
                    r_best   <= r_p3_j;
                end
            end
        end
    end

    // Scan datapath: read, square, sum and update.
    always_ff @(posedge i_clk) begin
        r_p1_j   <= r_j[AW-1:0];
        r_p2_j   <= r_p1_j;
        r_p2_old <= oldd_p1;
        r_sx     <= $unsigned(px);
        r_sy     <= $unsigned(py);
        r_sz     <= $unsigned(pz);
        r_p3_j   <= r_p2_j;
        r_p3_d   <= newd;
    end

    // Distance memory: read address follows the scan, write at stage two.
    always_ff @(posedge i_clk) begin
        r_dm1 <= r_dmem[r_j[AW-1:0]];
        if (r_p2_v) r_dmem[r_p2_j] <= newd;
    end
    assign oldd_p1 = r_first ? '1 : r_dm1;

    // Point memory.
    always_ff @(posedge i_clk) begin
        if (pop_q && i_q_cmd.wr) r_pmem[i_q_addr] <= i_q_pos;
        r_rd <= r_pmem[rd_addr];
    end

    assign o_valid       = r_out_v;
    assign o_point_index = r_oempty ? '0 : r_oidx;
    assign o_pos         = r_oempty ? '0 : r_ref;
    assign o_last_sample = r_olast;
    assign o_empty_res   = r_oempty;
    assign o_overflow    = r_odrop;
endmodule

// File: hdl/farthest_point_sampler_unit.sv
// Top level of the farthest point sampler: front end, command queue and
// sampling back end. Depends on fps_pkg, fps_if, fps_front and fps_back.
//
//  channel    direction  contents
//  in_ch      input      pos_x, pos_y, pos_z, last_point
//  out_ch     output     point_index, out_x/y/z, last_sample, empty_res, overflow
//  cfg_ch     input      sample_count
//
// A last word starts a run of cnt samples over n points; after the first
// sample, each further sample takes one pass over the point memory, and a
// cloud of no more than cnt points is emitted point by point in load order.
// Reset is synchronous, active low, and restores sample_count to 16. Output
// stalls hold the sequencer; the input side keeps filling a two-word queue
// meanwhile.
module farthest_point_sampler_unit #(
    parameter int unsigned MAX_POINTS  = 1024,
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fps_in_if.sink    in_ch,
    fps_out_if.source out_ch,
    fps_cfg_if.sink   cfg_ch
);
    import fps_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [CNT_W-1:0] r_sample_count;
    logic q_valid, q_pop;
    t_cmd q_cmd;
    logic [AW-1:0] q_addr;
    logic [AW:0] q_n;
    logic [3*COORD_W-1:0] q_pos, o_pos;

    // Configuration register.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sample_count <= SAMPLE_COUNT_RST;
        else if (cfg_ch.valid) r_sample_count <= cfg_ch.data;
    end

    fps_front #(.MAX_POINTS(MAX_POINTS), .MAX_SAMPLES(MAX_SAMPLES), .AW(AW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_pos({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z}),
        .i_last(in_ch.last_point), .i_sample_count(r_sample_count),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd),
        .o_q_addr(q_addr), .o_q_n(q_n), .o_q_pos(q_pos)
    );

    fps_back #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .i_q_addr(q_addr), .i_q_n(q_n), .i_q_pos(q_pos),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_point_index(out_ch.point_index), .o_pos(o_pos),
        .o_last_sample(out_ch.last_sample), .o_empty_res(out_ch.empty_res),
        .o_overflow(out_ch.overflow)
    );

    assign out_ch.out_x = o_pos[3*COORD_W-1 -: COORD_W];
    assign out_ch.out_y = o_pos[2*COORD_W-1 -: COORD_W];
    assign out_ch.out_z = o_pos[COORD_W-1:0];
endmodule
